### sv/caf_pkg.sv
`timescale 1ns / 1ps

package caf_pkg;

  // Table and field sizes.
  localparam int SCAN_ENTRIES = 16;
  localparam int FILTERS      = 3;
  localparam int ID_W         = 29;
  localparam int OCC_W        = 16;
  localparam int CNT_W        = 32;
  localparam int SLOT_W       = (SCAN_ENTRIES > 1) ? $clog2(SCAN_ENTRIES) : 1;
  localparam int USED_W       = $clog2(SCAN_ENTRIES + 1);
  localparam int REG_IDX_W    = 3;

  localparam logic [ID_W-1:0] STD_ID_MASK = ID_W'(11'h7FF);

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_FILTER0_ID   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FILTER0_MASK = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FILTER1_ID   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FILTER1_MASK = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FILTER2_ID   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FILTER2_MASK = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_FILTER_COUNT = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SCAN_ENABLE  = 3'd7;

  // Scan status codes.
  localparam logic [1:0] SCAN_NONE    = 2'd0;
  localparam logic [1:0] SCAN_COUNTED = 2'd1;
  localparam logic [1:0] SCAN_NEW     = 2'd2;
  localparam logic [1:0] SCAN_DROPPED = 2'd3;

  // Lookup token that travels one cell per cycle along the scan row.
  typedef struct packed {
    logic              valid;
    logic              done;
    logic [ID_W-1:0]   key;
    logic              ext;
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [OCC_W-1:0]  hits;
  } scan_tok_t;

endpackage

### sv/caf_scan_cell.sv
`timescale 1ns / 1ps

module caf_scan_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [caf_pkg::SLOT_W-1:0] cell_idx_i,
  input  logic [caf_pkg::USED_W-1:0] used_i,
  input  caf_pkg::scan_tok_t       tok_i,
  output caf_pkg::scan_tok_t       tok_o
);
  import caf_pkg::*;

  logic [ID_W-1:0]  ident_q;
  logic             ext_q;
  logic [OCC_W-1:0] occ_q;
  logic [OCC_W-1:0] occ_inc;
  logic             in_use;
  logic             hit;
  logic             append;
  scan_tok_t        tok_d;
  scan_tok_t        tok_q;

  // This cell holds a live entry only below the fill count; the first free
  // cell takes a new pair when no earlier cell claimed the token.
  assign in_use  = USED_W'(cell_idx_i) < used_i;
  assign hit     = tok_i.valid && !tok_i.done && in_use &&
                   (ident_q == tok_i.key) && (ext_q == tok_i.ext);
  assign append  = tok_i.valid && !tok_i.done && (USED_W'(cell_idx_i) == used_i);
  assign occ_inc = occ_q + OCC_W'(1);

  always_comb begin
    tok_d = tok_i;
    if (hit) begin
      tok_d.done   = 1'b1;
      tok_d.status = SCAN_COUNTED;
      tok_d.slot   = cell_idx_i;
      tok_d.hits   = occ_inc;
    end else if (append) begin
      tok_d.done   = 1'b1;
      tok_d.status = SCAN_NEW;
      tok_d.slot   = cell_idx_i;
      tok_d.hits   = OCC_W'(1);
    end
  end

  // Entry storage has no reset; it is only read below the fill count.
  always_ff @(posedge clk_i) begin
    if (hit) begin
      occ_q <= occ_inc;
    end else if (append) begin
      ident_q <= tok_i.key;
      ext_q   <= tok_i.ext;
      occ_q   <= OCC_W'(1);
    end
  end

  // Token register toward the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

### sv/can_acceptance_filter_id_scanner.sv
`timescale 1ns / 1ps

// CAN identifier acceptance filter and identifier scanner. An item is taken
// when start_i is high and busy_o is low; its result appears on the result
// ports for exactly one cycle with done_o high, and must be captured then.
// A clear command, or a frame while scanning is disabled, gives its result
// in the cycle after it is taken. With scanning enabled the lookup token
// walks the row of SCAN_ENTRIES scan cells one cell per cycle, busy_o stays
// high while it walks, and the result is registered when it leaves the last
// cell. A new item may be started in the cycle that done_o is high.
// Configuration writes are always ready and must only be issued while the
// block is idle.
module can_acceptance_filter_id_scanner (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        command_i,
  input  logic                        is_ext_i,
  input  logic [caf_pkg::ID_W-1:0]    frame_id_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [caf_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [caf_pkg::ID_W-1:0]    cfg_data_i,
  output logic                        done_o,
  output logic [2:0]                  filter_hits_o,
  output logic                        matched_o,
  output logic [1:0]                  scan_status_o,
  output logic [3:0]                  scan_slot_o,
  output logic [caf_pkg::OCC_W-1:0]   scan_hits_o,
  output logic [caf_pkg::CNT_W-1:0]   frames_seen_o,
  output logic [caf_pkg::CNT_W-1:0]   frames_dispatched_o
);
  import caf_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                state_q;
  logic                done_q;
  logic [ID_W-1:0]     filt_id_q   [FILTERS];
  logic [ID_W-1:0]     filt_mask_q [FILTERS];
  logic [1:0]          filter_count_q;
  logic                scan_en_q;
  logic [USED_W-1:0]   used_q;
  logic [CNT_W-1:0]    rx_total_q;
  logic [CNT_W-1:0]    acc_total_q;
  logic [FILTERS-1:0]  hits_q;
  logic [FILTERS-1:0]  out_hits_q;
  logic [1:0]          out_status_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [OCC_W-1:0]    out_occ_q;

  logic                take;
  logic                frame_take;
  logic [ID_W-1:0]     frame_key;
  logic [FILTERS-1:0]  hit_vec;
  scan_tok_t           inject_tok;
  scan_tok_t           tok_chain [SCAN_ENTRIES];

  assign take        = start_i && (state_q == ST_IDLE);
  assign frame_take  = take && !command_i;
  assign cfg_ready_o = 1'b1;
  assign frame_key   = is_ext_i ? frame_id_i : (frame_id_i & STD_ID_MASK);

  // Filter bank: mask zero means exact standard match, otherwise a masked
  // extended match; only filters below filter_count_q can hit.
  always_comb begin
    for (int i = 0; i < FILTERS; i++) begin
      if (filt_mask_q[i] == '0) begin
        hit_vec[i] = !is_ext_i && (filt_id_q[i] == frame_key);
      end else begin
        hit_vec[i] = is_ext_i && (((frame_key ^ filt_id_q[i]) & filt_mask_q[i]) == '0);
      end
      hit_vec[i] = hit_vec[i] && (i < int'(filter_count_q));
    end
  end

  // Token entering the first cell.
  always_comb begin
    inject_tok        = '0;
    inject_tok.valid  = frame_take && scan_en_q;
    inject_tok.key    = frame_key;
    inject_tok.ext    = is_ext_i;
    inject_tok.status = SCAN_NONE;
  end

  // Row of scan cells.
  for (genvar k = 0; k < SCAN_ENTRIES; k++) begin : g_cell
    scan_tok_t tok_in;
    if (k == 0) begin : g_first
      assign tok_in = inject_tok;
    end else begin : g_next
      assign tok_in = tok_chain[k-1];
    end
    caf_scan_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (SLOT_W'(k)),
      .used_i     (used_q),
      .tok_i      (tok_in),
      .tok_o      (tok_chain[k])
    );
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FILTERS; i++) begin
        filt_id_q[i]   <= '0;
        filt_mask_q[i] <= '0;
      end
      filter_count_q <= '0;
      scan_en_q      <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_FILTER0_ID:   filt_id_q[0]   <= cfg_data_i;
        REG_FILTER0_MASK: filt_mask_q[0] <= cfg_data_i;
        REG_FILTER1_ID:   filt_id_q[1]   <= cfg_data_i;
        REG_FILTER1_MASK: filt_mask_q[1] <= cfg_data_i;
        REG_FILTER2_ID:   filt_id_q[2]   <= cfg_data_i;
        REG_FILTER2_MASK: filt_mask_q[2] <= cfg_data_i;
        REG_FILTER_COUNT: filter_count_q <= cfg_data_i[1:0];
        REG_SCAN_ENABLE:  scan_en_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer, counters and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      done_q      <= 1'b0;
      used_q      <= '0;
      rx_total_q  <= '0;
      acc_total_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (take && command_i) begin
            used_q <= '0;
            done_q <= 1'b1;
          end else if (frame_take) begin
            rx_total_q <= rx_total_q + CNT_W'(1);
            if (hit_vec != '0) begin
              acc_total_q <= acc_total_q + CNT_W'(1);
            end
            if (scan_en_q) begin
              state_q <= ST_SCAN;
            end else begin
              done_q <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (tok_chain[SCAN_ENTRIES-1].valid) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
            if (tok_chain[SCAN_ENTRIES-1].status == SCAN_NEW) begin
              used_q <= used_q + USED_W'(1);
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (take) begin
      hits_q       <= command_i ? '0 : hit_vec;
      out_hits_q   <= command_i ? '0 : hit_vec;
      out_status_q <= SCAN_NONE;
      out_slot_q   <= '0;
      out_occ_q    <= '0;
    end else if ((state_q == ST_SCAN) && tok_chain[SCAN_ENTRIES-1].valid) begin
      out_hits_q <= hits_q;
      if (tok_chain[SCAN_ENTRIES-1].done) begin
        out_status_q <= tok_chain[SCAN_ENTRIES-1].status;
        out_slot_q   <= tok_chain[SCAN_ENTRIES-1].slot;
        out_occ_q    <= tok_chain[SCAN_ENTRIES-1].hits;
      end else begin
        out_status_q <= SCAN_DROPPED;
        out_slot_q   <= '0;
        out_occ_q    <= '0;
      end
    end
  end

  assign busy_o              = (state_q == ST_SCAN);
  assign done_o              = done_q;
  assign filter_hits_o       = 3'(out_hits_q);
  assign matched_o           = (out_hits_q != '0);
  assign scan_status_o       = out_status_q;
  assign scan_slot_o         = 4'(out_slot_q);
  assign scan_hits_o         = out_occ_q;
  assign frames_seen_o       = rx_total_q;
  assign frames_dispatched_o = acc_total_q;

endmodule

### sv/caf_checker.sv
`timescale 1ns / 1ps

module caf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        done_o,
  input logic [2:0]                  filter_hits_o,
  input logic                        matched_o,
  input logic [1:0]                  scan_status_o,
  input logic [3:0]                  scan_slot_o,
  input logic [caf_pkg::OCC_W-1:0]   scan_hits_o,
  input logic [caf_pkg::CNT_W-1:0]   frames_seen_o
);
  import caf_pkg::*;

  // The matched flag summarizes the hit bitmap.
  a_matched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (matched_o == (filter_hits_o != 3'd0)))
    else $error("matched disagrees with filter hits");

  // Slot and count are zero unless an entry was touched.
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (scan_status_o == SCAN_NONE || scan_status_o == SCAN_DROPPED))
      |-> (scan_slot_o == 4'd0 && scan_hits_o == '0))
    else $error("slot or count set for an untouched entry");

  // A new entry always starts at one occurrence.
  a_new_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && scan_status_o == SCAN_NEW) |-> (scan_hits_o == OCC_W'(1)))
    else $error("new entry count is not one");

  // The end of a scan is reported right away.
  a_scan_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("scan ended without a result");

  // The frame count advances by at most one per taken item.
  a_seen_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=>
      (frames_seen_o == $past(frames_seen_o) ||
       frames_seen_o == $past(frames_seen_o) + CNT_W'(1)))
    else $error("frame count jumped");

endmodule

bind can_acceptance_filter_id_scanner caf_checker u_caf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .filter_hits_o (filter_hits_o),
  .matched_o     (matched_o),
  .scan_status_o (scan_status_o),
  .scan_slot_o   (scan_slot_o),
  .scan_hits_o   (scan_hits_o),
  .frames_seen_o (frames_seen_o)
);

### tb/can_acceptance_filter_id_scanner_test.sv
`timescale 1ns / 1ps

module can_acceptance_filter_id_scanner_test;
  import caf_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int POOL_SIZE   = 20;
  localparam int PHASE_ITEMS = 130;
  localparam int REPEAT_RUN  = 40;

  typedef enum bit {
    CMD_FRAME = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  // One result as seen on the block's outputs.
  typedef struct packed {
    logic [2:0]        hits;
    logic              matched;
    logic [1:0]        status;
    logic [3:0]        slot;
    logic [OCC_W-1:0]  occ;
    logic [CNT_W-1:0]  seen;
    logic [CNT_W-1:0]  dispatched;
  } verdict_t;

  // Tracks the filter setup and the scan table, predicts the verdict of each
  // accepted item and checks the verdicts that come back, in order.
  class frame_filter_scoreboard;
    logic [ID_W-1:0]  flt_id[FILTERS];
    logic [ID_W-1:0]  flt_mask[FILTERS];
    int unsigned      flt_used;
    bit               scan_on;
    logic [ID_W-1:0]  tbl_key[SCAN_ENTRIES];
    bit               tbl_ext[SCAN_ENTRIES];
    logic [OCC_W-1:0] tbl_occ[SCAN_ENTRIES];
    int unsigned      tbl_used;
    logic [CNT_W-1:0] rx_count;
    logic [CNT_W-1:0] accepted_count;
    verdict_t         expected_verdicts[$];
    int unsigned      results_seen;
    int unsigned      mismatches;
    int unsigned      status_tally[4];
    int unsigned      matched_tally;

    function new();
      for (int i = 0; i < FILTERS; i++) begin
        flt_id[i]   = '0;
        flt_mask[i] = '0;
      end
      flt_used       = 0;
      scan_on        = 1'b0;
      tbl_used       = 0;
      rx_count       = '0;
      accepted_count = '0;
      results_seen   = 0;
      mismatches     = 0;
      matched_tally  = 0;
      for (int i = 0; i < 4; i++) status_tally[i] = 0;
    endfunction

    function void write_register(logic [REG_IDX_W-1:0] idx, logic [ID_W-1:0] data);
      case (idx)
        REG_FILTER0_ID:   flt_id[0]   = data;
        REG_FILTER0_MASK: flt_mask[0] = data;
        REG_FILTER1_ID:   flt_id[1]   = data;
        REG_FILTER1_MASK: flt_mask[1] = data;
        REG_FILTER2_ID:   flt_id[2]   = data;
        REG_FILTER2_MASK: flt_mask[2] = data;
        REG_FILTER_COUNT: flt_used    = data[1:0];
        REG_SCAN_ENABLE:  scan_on     = data[0];
        default: ;
      endcase
    endfunction

    function void note_frame(cmd_e cmd, bit ext, logic [ID_W-1:0] fid);
      verdict_t        v;
      logic [ID_W-1:0] key;
      bit              found;
      bit              hit;
      v = '0;
      if (cmd == CMD_CLEAR) begin
        tbl_used = 0;
      end else begin
        // A standard frame is identified by its low 11 bits only.
        key = ext ? fid : (fid & STD_ID_MASK);
        rx_count++;
        if (scan_on) begin
          found = 1'b0;
          for (int i = 0; i < int'(tbl_used) && !found; i++) begin
            if (tbl_key[i] == key && tbl_ext[i] == ext) begin
              tbl_occ[i]++;
              found    = 1'b1;
              v.status = SCAN_COUNTED;
              v.slot   = 4'(i);
              v.occ    = tbl_occ[i];
            end
          end
          if (!found) begin
            if (tbl_used < SCAN_ENTRIES) begin
              tbl_key[tbl_used] = key;
              tbl_ext[tbl_used] = ext;
              tbl_occ[tbl_used] = OCC_W'(1);
              v.status = SCAN_NEW;
              v.slot   = 4'(tbl_used);
              v.occ    = OCC_W'(1);
              tbl_used++;
            end else begin
              v.status = SCAN_DROPPED;
            end
          end
        end
        // Mask zero means an exact standard match, otherwise a masked extended one.
        for (int i = 0; i < int'(flt_used) && i < FILTERS; i++) begin
          if (flt_mask[i] == '0) hit = !ext && (flt_id[i] == key);
          else hit = ext && ((key & flt_mask[i]) == (flt_id[i] & flt_mask[i]));
          if (hit) v.hits[i] = 1'b1;
        end
        if (v.hits != '0) accepted_count++;
      end
      v.matched    = |v.hits;
      v.seen       = rx_count;
      v.dispatched = accepted_count;
      expected_verdicts.push_back(v);
    endfunction

    function void report(string what, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch on result %0d, %s: expected %0h, got %0h",
                 results_seen, what, want, got);
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      results_seen++;
      if (expected_verdicts.size() == 0) begin
        report("result with no item waiting", '0, '1);
      end else begin
        want = expected_verdicts.pop_front();
        status_tally[want.status]++;
        if (want.matched) matched_tally++;
        if (got.hits !== want.hits) report("filter_hits", want.hits, got.hits);
        if (got.matched !== want.matched) report("matched", want.matched, got.matched);
        if (got.status !== want.status) report("scan_status", want.status, got.status);
        if (got.slot !== want.slot) report("scan_slot", want.slot, got.slot);
        if (got.occ !== want.occ) report("scan_hits", want.occ, got.occ);
        if (got.seen !== want.seen) report("frames_seen", want.seen, got.seen);
        if (got.dispatched !== want.dispatched)
          report("frames_dispatched", want.dispatched, got.dispatched);
      end
    endfunction

    function int unsigned pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic                 command_i;
  logic                 is_ext_i;
  logic [ID_W-1:0]      frame_id_i;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [REG_IDX_W-1:0] cfg_index_i;
  logic [ID_W-1:0]      cfg_data_i;
  logic                 done_o;
  logic [2:0]           filter_hits_o;
  logic                 matched_o;
  logic [1:0]           scan_status_o;
  logic [3:0]           scan_slot_o;
  logic [OCC_W-1:0]     scan_hits_o;
  logic [CNT_W-1:0]     frames_seen_o;
  logic [CNT_W-1:0]     frames_dispatched_o;

  frame_filter_scoreboard sb = new();

  // Current filter setup, kept here to aim the stimulus at the filters.
  logic [ID_W-1:0] set_id[FILTERS];
  logic [ID_W-1:0] set_mask[FILTERS];
  logic [1:0]      set_count;
  bit              set_scan;

  // Identifier pool of the current phase, so that pairs repeat in the scan table.
  bit              pool_ext[POOL_SIZE];
  logic [ID_W-1:0] pool_id[POOL_SIZE];

  int unsigned items_sent;
  int unsigned clears_sent;
  int unsigned setups_loaded;
  int unsigned quiet_cycles;

  can_acceptance_filter_id_scanner DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .command_i          (command_i),
    .is_ext_i           (is_ext_i),
    .frame_id_i         (frame_id_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .done_o             (done_o),
    .filter_hits_o      (filter_hits_o),
    .matched_o          (matched_o),
    .scan_status_o      (scan_status_o),
    .scan_slot_o        (scan_slot_o),
    .scan_hits_o        (scan_hits_o),
    .frames_seen_o      (frames_seen_o),
    .frames_dispatched_o(frames_dispatched_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Monitor: results first, then register writes, then newly taken items.
  always @(posedge clk_i) begin
    verdict_t got;
    bit       busy_step;
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      busy_step = 1'b0;
      if (done_o) begin
        got.hits       = filter_hits_o;
        got.matched    = matched_o;
        got.status     = scan_status_o;
        got.slot       = scan_slot_o;
        got.occ        = scan_hits_o;
        got.seen       = frames_seen_o;
        got.dispatched = frames_dispatched_o;
        sb.check_result(got);
        busy_step = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        sb.write_register(cfg_index_i, cfg_data_i);
        busy_step = 1'b1;
      end
      if (start_i && !busy_o) begin
        sb.note_frame(cmd_e'(command_i), is_ext_i, frame_id_i);
        busy_step = 1'b1;
      end
      quiet_cycles <= busy_step ? 0 : quiet_cycles + 1;
    end
  end

  // Watchdog on cycles in which nothing at all is accepted.
  initial begin
    quiet_cycles = 0;
    wait (rst_ni === 1'b1);
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("Timeout: nothing accepted for %0d cycles", STALL_LIMIT);
    $display("can_acceptance_filter_id_scanner_test NOT OK");
    $finish;
  end

  // Holds an item on the inputs until the block takes it. Leaves start high.
  task automatic push_item(cmd_e cmd, bit ext, logic [ID_W-1:0] fid);
    start_i    <= 1'b1;
    command_i  <= cmd;
    is_ext_i   <= ext;
    frame_id_i <= fid;
    items_sent++;
    if (cmd == CMD_CLEAR) clears_sent++;
    do @(posedge clk_i); while (busy_o !== 1'b0);
  endtask

  // Must be called in the step in which the last item was taken.
  task automatic idle_gap(int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Waits until every taken item has produced its result. Start must be low.
  task automatic wait_drained();
    while (sb.results_seen < items_sent) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [ID_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
  endtask

  // Writes every register from the current setup; upper bits of the narrow
  // registers carry random junk that the block must ignore.
  task automatic load_setup();
    write_reg(REG_FILTER0_ID,   set_id[0]);
    write_reg(REG_FILTER0_MASK, set_mask[0]);
    write_reg(REG_FILTER1_ID,   set_id[1]);
    write_reg(REG_FILTER1_MASK, set_mask[1]);
    write_reg(REG_FILTER2_ID,   set_id[2]);
    write_reg(REG_FILTER2_MASK, set_mask[2]);
    write_reg(REG_FILTER_COUNT, (ID_W'($urandom) & ~ID_W'(3)) | ID_W'(set_count));
    write_reg(REG_SCAN_ENABLE,  (ID_W'($urandom) & ~ID_W'(1)) | ID_W'(set_scan));
    cfg_valid_i <= 1'b0;
    setups_loaded++;
  endtask

  // A frame aimed at filter i: one it should accept, with random free bits.
  function automatic void aim_at_filter(int i, output bit ext, output logic [ID_W-1:0] fid);
    if (set_mask[i] == '0) begin
      ext = 1'b0;
      fid = (ID_W'($urandom) & ~STD_ID_MASK) | (set_id[i] & STD_ID_MASK);
    end else begin
      ext = 1'b1;
      fid = (set_id[i] & set_mask[i]) | (ID_W'($urandom) & ~set_mask[i]);
    end
  endfunction

  // Random filter setup and identifier pool for one phase.
  task automatic choose_setup(int phase);
    for (int i = 0; i < FILTERS; i++) begin
      case ($urandom_range(3))
        0: begin
          set_mask[i] = '0;
          set_id[i]   = ID_W'($urandom_range(11'h7FF));
        end
        1: begin
          // Exact filter wider than 11 bits: it can never match.
          set_mask[i] = '0;
          set_id[i]   = ID_W'($urandom) | (ID_W'(1) << $urandom_range(ID_W - 1, 11));
        end
        2: begin
          set_mask[i] = ID_W'($urandom) | ID_W'(1);
          set_id[i]   = ID_W'($urandom);
        end
        default: begin
          set_mask[i] = (ID_W'($urandom) & ID_W'($urandom) & ID_W'($urandom))
                        | (ID_W'(1) << $urandom_range(ID_W - 1));
          set_id[i]   = ID_W'($urandom);
        end
      endcase
    end
    set_count = 2'($urandom_range(3));
    set_scan  = $urandom_range(9) != 0;
    if (phase == 1) set_count = 2'd0;
    if (phase == 2) set_scan = 1'b0;
    for (int k = 0; k < POOL_SIZE; k++) begin
      if ($urandom_range(1)) begin
        aim_at_filter($urandom_range(FILTERS - 1), pool_ext[k], pool_id[k]);
      end else begin
        pool_ext[k] = $urandom_range(1);
        pool_id[k]  = ID_W'($urandom);
      end
    end
  endtask

  // Mostly pool and filter-aimed frames, some noise, a few clears.
  function automatic void pick_item(output cmd_e cmd, output bit ext,
                                    output logic [ID_W-1:0] fid);
    int unsigned r;
    int unsigned j;
    r   = $urandom_range(99);
    cmd = CMD_FRAME;
    ext = $urandom_range(1);
    fid = ID_W'($urandom);
    if (r < 3) begin
      cmd = CMD_CLEAR;
    end else if (r < 60) begin
      j   = $urandom_range(POOL_SIZE - 1);
      ext = pool_ext[j];
      fid = pool_ext[j] ? pool_id[j]
                        : (ID_W'($urandom) & ~STD_ID_MASK) | (pool_id[j] & STD_ID_MASK);
    end else if (r < 85) begin
      aim_at_filter($urandom_range(FILTERS - 1), ext, fid);
    end
  endfunction

  task automatic run_phase(int unsigned count, bit with_gaps);
    cmd_e            cmd;
    bit              ext;
    logic [ID_W-1:0] fid;
    int unsigned     gap_pct;
    gap_pct = 0;
    for (int unsigned k = 0; k < count; k++) begin
      // Idling density changes every 40 items, including stretches of none.
      if (k % 40 == 0) gap_pct = with_gaps ? 30 * $urandom_range(2) : 0;
      pick_item(cmd, ext, fid);
      push_item(cmd, ext, fid);
      if (k == count - 1) begin
        start_i <= 1'b0;
      end else if (with_gaps && $urandom_range(99) == 0) begin
        start_i <= 1'b0;
        wait_drained();
      end else if ($urandom_range(99) < gap_pct) begin
        idle_gap($urandom_range(8, 1));
      end
    end
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    command_i     = 1'b0;
    is_ext_i      = 1'b0;
    frame_id_i    = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    items_sent    = 0;
    clears_sent   = 0;
    setups_loaded = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: exact standard filter at the top of the 11-bit range, a
    // full-mask extended filter, and a partial-mask extended filter.
    set_id[0]   = ID_W'(11'h7FF);
    set_mask[0] = '0;
    set_id[1]   = '1;
    set_mask[1] = '1;
    set_id[2]   = ID_W'(29'h0ABCDE00);
    set_mask[2] = ID_W'(29'h1FFFFF00);
    set_count   = 2'd3;
    set_scan    = 1'b1;
    load_setup();
    push_item(CMD_FRAME, 1'b0, ID_W'(29'h000007FF));
    // Standard frame with junk above bit 10 hits the same filter and scan entry.
    push_item(CMD_FRAME, 1'b0, ID_W'(29'h1FFFF7FF));
    // Same identifier as an extended frame: different pair, no exact match.
    push_item(CMD_FRAME, 1'b1, ID_W'(29'h000007FF));
    push_item(CMD_FRAME, 1'b1, '1);
    push_item(CMD_FRAME, 1'b1, ID_W'(29'h0ABCDEFF));
    push_item(CMD_FRAME, 1'b0, '0);
    push_item(CMD_FRAME, 1'b1, '0);
    push_item(CMD_CLEAR, 1'b0, '0);
    push_item(CMD_FRAME, 1'b0, ID_W'(29'h000007FF));
    // Fill the scan table, then overflow it, then hit an existing entry.
    for (int i = 1; i <= SCAN_ENTRIES; i++) push_item(CMD_FRAME, 1'b0, ID_W'(i));
    push_item(CMD_FRAME, 1'b0, ID_W'(29'h000007FF));
    start_i <= 1'b0;
    wait_drained();

    // Random phases under changing filter setups, with idling on the sender.
    for (int phase = 0; phase < 7; phase++) begin
      choose_setup(phase);
      load_setup();
      run_phase(PHASE_ITEMS, 1'b1);
    end

    // Extreme setup for the rest of the run.
    set_id[0]   = '0;
    set_mask[0] = '0;
    set_id[1]   = '0;
    set_mask[1] = '1;
    set_id[2]   = '1;
    set_mask[2] = '1;
    set_count   = 2'd3;
    set_scan    = 1'b1;
    load_setup();

    // One pair repeated many times, so its occurrence count climbs in one slot.
    push_item(CMD_CLEAR, 1'b1, '1);
    for (int i = 0; i < REPEAT_RUN; i++) push_item(CMD_FRAME, 1'b1, ID_W'(29'h15555555));
    start_i <= 1'b0;
    wait_drained();

    // Last part: back-to-back items, no idling.
    for (int k = 0; k < POOL_SIZE; k++) begin
      aim_at_filter(k % FILTERS, pool_ext[k], pool_id[k]);
      if (k % 4 == 3) pool_id[k] = ID_W'($urandom);
    end
    run_phase(PHASE_ITEMS, 1'b0);

    repeat (40) @(posedge clk_i);
    $display("Ran %0d items (%0d clears) under %0d register setups; %0d results checked.",
             items_sent, clears_sent, setups_loaded, sb.results_seen);
    $display("Scan outcomes: %0d not recorded, %0d counted, %0d new, %0d dropped; %0d matched.",
             sb.status_tally[0], sb.status_tally[1], sb.status_tally[2],
             sb.status_tally[3], sb.matched_tally);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("can_acceptance_filter_id_scanner_test OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("can_acceptance_filter_id_scanner_test NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
sv/caf_pkg.sv
sv/caf_scan_cell.sv
sv/can_acceptance_filter_id_scanner.sv
sv/caf_checker.sv
tb/can_acceptance_filter_id_scanner_test.sv
